// ----- rtl/core/chtl_pkg.sv -----
// shared types, constants and helpers for the cascaded trend lowpass
package chtl_pkg;

  localparam int STAGES      = 8;
  localparam int STAGE_W     = $clog2(STAGES);
  localparam int SAMPLE_BITS = 24;
  localparam int STATE_W     = 32;
  localparam int OPND_W      = STATE_W + 1;
  localparam int COEF_W      = 18;
  localparam int ACC_W       = OPND_W + COEF_W + 2;
  localparam int CNT_W       = $clog2(COEF_W);
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int DEPTH_W     = 16;
  localparam int WEIGHT_W    = 13;

  localparam logic signed [COEF_W-1:0] COEF_ONE  = 18'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_C999 = 18'sd65470;
  localparam logic [WEIGHT_W-1:0]      DEPTH_ONE = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 3'd0,
    REG_BETA  = 3'd1,
    REG_DEPTH = 3'd2,
    REG_GAIN  = 3'd3,
    REG_WET   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [16:0]        alpha;
    logic [16:0]        beta;
    logic [DEPTH_W-1:0] depth;
    logic [16:0]        gain;
    logic [16:0]        wet;
  } cfg_t;

  typedef struct packed {
    logic                     start;
    logic                     frac12;
    logic signed [OPND_W-1:0] a1;
    logic signed [OPND_W-1:0] a2;
    logic signed [COEF_W-1:0] c1;
    logic signed [COEF_W-1:0] c2;
  } mac_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [STATE_W-1:0] result;
  } mac_rsp_t;

  // engagement of one stage, clamped to 0..1.0 in Q12
  function automatic logic [WEIGHT_W-1:0] stage_weight(input logic [DEPTH_W-1:0] depth,
                                                       input logic [STAGE_W-1:0] idx);
    logic signed [DEPTH_W+1:0] w;
    w = $signed({2'b00, depth}) - $signed({{(DEPTH_W+2-STAGE_W-12){1'b0}}, idx, 12'b0});
    if (w <= 0) begin
      return '0;
    end else if (w > $signed({{(DEPTH_W+2-WEIGHT_W){1'b0}}, DEPTH_ONE})) begin
      return DEPTH_ONE;
    end else begin
      return w[WEIGHT_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/core/chtl_in_if.sv -----
// input sample channel
interface chtl_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [chtl_pkg::SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

// ----- rtl/core/chtl_out_if.sv -----
// output sample channel
interface chtl_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [chtl_pkg::SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/core/chtl_cfg.sv -----
// configuration register bank with coefficient clamping
module chtl_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [chtl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [chtl_pkg::CFG_DATA_W-1:0]    cfg_data,
  output chtl_pkg::cfg_t                     cfg
);
  import chtl_pkg::*;

  logic [16:0]        alpha;
  logic [16:0]        beta;
  logic [DEPTH_W-1:0] depth;
  logic [16:0]        gain;
  logic [16:0]        wet;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= 17'd65536;
      beta  <= 17'd2492;
      depth <= 16'd4096;
      gain  <= 17'd65536;
      wet   <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA: alpha <= cfg_data;
        REG_BETA:  beta  <= cfg_data;
        REG_DEPTH: depth <= cfg_data[DEPTH_W-1:0];
        REG_GAIN:  gain  <= cfg_data;
        REG_WET:   wet   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // coefficients above one act as one
  always_comb begin
    cfg.alpha = (alpha > 17'd65536) ? 17'd65536 : alpha;
    cfg.beta  = (beta > 17'd65536) ? 17'd65536 : beta;
    cfg.depth = depth;
    cfg.gain  = gain;
    cfg.wet   = wet;
  end

endmodule

// ----- rtl/core/chtl_mac.sv -----
// bit-serial dual multiply-accumulate with rounding shift and 32-bit saturation
module chtl_mac (
  input  logic                clk,
  input  logic                rst,
  input  chtl_pkg::mac_req_t  req,
  output chtl_pkg::mac_rsp_t  rsp
);
  import chtl_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W)'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W)'(64'sd2147483648);

  logic                     busy;
  logic                     post;
  logic                     done;
  logic [CNT_W-1:0]         cnt;
  logic                     frac12;
  logic signed [OPND_W-1:0] a1;
  logic signed [OPND_W-1:0] a2;
  logic [COEF_W-1:0]        c1sh;
  logic [COEF_W-1:0]        c2sh;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [ACC_W-1:0]  t1;
  logic signed [ACC_W-1:0]  t2;
  logic signed [ACC_W-1:0]  r16;
  logic signed [ACC_W-1:0]  r12;
  logic signed [ACC_W-1:0]  rsel;
  logic signed [STATE_W-1:0] result;

  // msb first, the sign bit carries negative weight
  always_comb begin
    t1 = c1sh[COEF_W-1] ? {{(ACC_W-OPND_W){a1[OPND_W-1]}}, a1} : '0;
    t2 = c2sh[COEF_W-1] ? {{(ACC_W-OPND_W){a2[OPND_W-1]}}, a2} : '0;
    if (cnt == CNT_W'(COEF_W-1)) begin
      acc_next = '0 - t1 - t2;
    end else begin
      acc_next = (acc <<< 1) + t1 + t2;
    end
  end

  always_comb begin
    r16  = (acc + (ACC_W)'(64'sd32768)) >>> 16;
    r12  = (acc + (ACC_W)'(64'sd2048)) >>> 12;
    rsel = frac12 ? r12 : r16;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      post <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy && !post) begin
        busy   <= 1'b1;
        cnt    <= CNT_W'(COEF_W-1);
        frac12 <= req.frac12;
        a1     <= req.a1;
        a2     <= req.a2;
        c1sh   <= req.c1;
        c2sh   <= req.c2;
      end else if (busy) begin
        acc  <= acc_next;
        c1sh <= c1sh << 1;
        c2sh <= c2sh << 1;
        cnt  <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          post <= 1'b1;
        end
      end else if (post) begin
        post <= 1'b0;
        done <= 1'b1;
        if (rsel > SAT_HI) begin
          result <= 32'sh7FFFFFFF;
        end else if (rsel < SAT_LO) begin
          result <= 32'sh80000000;
        end else begin
          result <= rsel[STATE_W-1:0];
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = result;

endmodule

// ----- rtl/core/cascaded_holt_trend_lowpass.sv -----
// cascaded trend-smoothing lowpass, top level with stage sequencer
//
// channel  | dir | payload           | handshake
// in_ch    | in  | sample_in  s24    | valid/ready
// out_ch   | out | sample_out s24    | valid/ready
// cfg      | in  | cfg_index, data17 | cfg_we, no wait
//
// each mac pass goes through the shared bit-serial mac unit:
// 2 passes per full stage, 3 for a partly engaged one, one each for gain and
// dry/wet below unity, none for a bypassed one
// the result waits in the output register; a new request is taken meanwhile
// reset clears the control registers and the per-stage sample and trend state
module cascaded_holt_trend_lowpass (
  input  logic                            clk,
  input  logic                            rst,
  chtl_in_if.sink                         in_ch,
  chtl_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [chtl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chtl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import chtl_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TREND = 7'b0000010,
    S_YOUT  = 7'b0000100,
    S_BLEND = 7'b0001000,
    S_GAIN  = 7'b0010000,
    S_WET   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                        state;
  logic                          pend;
  logic [STAGE_W-1:0]            stage;
  logic signed [SAMPLE_BITS-1:0] dry;
  logic signed [STATE_W-1:0]     x;
  logic signed [STATE_W-1:0]     prev_y;
  logic signed [STATE_W-1:0]     y;
  logic signed [STATE_W-1:0]     trend;
  logic signed [STATE_W-1:0]     samp [STAGES];
  logic signed [STATE_W-1:0]     trnd [STAGES];
  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;

  cfg_t                          cfg;
  mac_req_t                      mac_req;
  mac_rsp_t                      mac_rsp;
  logic [WEIGHT_W-1:0]           wcur;
  logic [WEIGHT_W-1:0]           wnext;
  logic [STAGE_W-1:0]            stage_inc;
  logic                          last_stage;
  logic signed [STATE_W-1:0]     ps;
  logic signed [STATE_W-1:0]     pt;
  logic signed [STATE_W-1:0]     other;
  logic signed [SAMPLE_BITS-1:0] x_sat;

  chtl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  chtl_mac u_mac (
    .clk (clk),
    .rst (rst),
    .req (mac_req),
    .rsp (mac_rsp)
  );

  assign wcur       = stage_weight(cfg.depth, stage);
  assign stage_inc  = stage + STAGE_W'(1);
  assign last_stage = (stage == STAGE_W'(STAGES-1));
  assign wnext      = stage_weight(cfg.depth, stage_inc);
  assign ps         = samp[stage];
  assign pt         = trnd[stage];
  assign other      = (stage == '0) ? STATE_W'(dry) : prev_y;

  always_comb begin
    if (x > STATE_W'(32'sd8388607)) begin
      x_sat = 24'sh7FFFFF;
    end else if (x < -STATE_W'(32'sd8388608)) begin
      x_sat = 24'sh800000;
    end else begin
      x_sat = x[SAMPLE_BITS-1:0];
    end
  end

  // operand selection for the shared mac
  always_comb begin
    mac_req.start  = 1'b0;
    mac_req.frac12 = 1'b0;
    mac_req.a1     = '0;
    mac_req.a2     = '0;
    mac_req.c1     = '0;
    mac_req.c2     = '0;
    case (state)
      S_TREND: begin
        mac_req.start = !pend;
        mac_req.a1    = OPND_W'(x) - OPND_W'(ps);
        mac_req.a2    = OPND_W'(pt);
        mac_req.c1    = $signed({1'b0, cfg.beta});
        mac_req.c2    = COEF_C999 - $signed({1'b0, cfg.beta});
      end
      S_YOUT: begin
        mac_req.start = !pend;
        mac_req.a1    = OPND_W'(x);
        mac_req.a2    = OPND_W'(ps) + OPND_W'(pt);
        mac_req.c1    = $signed({1'b0, cfg.alpha});
        mac_req.c2    = COEF_C999 - $signed({1'b0, cfg.alpha});
      end
      S_BLEND: begin
        mac_req.start  = !pend;
        mac_req.frac12 = 1'b1;
        mac_req.a1     = OPND_W'(y);
        mac_req.a2     = OPND_W'(other);
        mac_req.c1     = $signed({(COEF_W-WEIGHT_W)'(0), wcur});
        mac_req.c2     = $signed({(COEF_W-WEIGHT_W)'(0), DEPTH_ONE - wcur});
      end
      S_GAIN: begin
        mac_req.start = !pend && !cfg.gain[16];
        mac_req.a1    = OPND_W'(x);
        mac_req.c1    = $signed({1'b0, cfg.gain});
      end
      S_WET: begin
        mac_req.start = !pend && !cfg.wet[16];
        mac_req.a1    = OPND_W'(x);
        mac_req.a2    = OPND_W'(dry);
        mac_req.c1    = $signed({1'b0, cfg.wet});
        mac_req.c2    = COEF_ONE - $signed({1'b0, cfg.wet});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      stage     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < STAGES; i++) begin
        samp[i] <= '0;
        trnd[i] <= '0;
      end
    end else begin
      if (out_valid && out_ch.ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (mac_req.start) begin
        pend <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            dry   <= in_ch.sample_in;
            x     <= STATE_W'(in_ch.sample_in);
            stage <= '0;
            state <= (stage_weight(cfg.depth, '0) != '0) ? S_TREND : S_GAIN;
          end
        end
        S_TREND: begin
          if (mac_rsp.done) begin
            pend  <= 1'b0;
            trend <= mac_rsp.result;
            state <= S_YOUT;
          end
        end
        S_YOUT: begin
          if (mac_rsp.done) begin
            pend        <= 1'b0;
            y           <= mac_rsp.result;
            samp[stage] <= mac_rsp.result;
            trnd[stage] <= trend;
            if (wcur == DEPTH_ONE) begin
              x      <= mac_rsp.result;
              prev_y <= mac_rsp.result;
              if (last_stage || wnext == '0) begin
                state <= S_GAIN;
              end else begin
                stage <= stage_inc;
                state <= S_TREND;
              end
            end else begin
              state <= S_BLEND;
            end
          end
        end
        S_BLEND: begin
          if (mac_rsp.done) begin
            pend   <= 1'b0;
            x      <= mac_rsp.result;
            prev_y <= y;
            state  <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (cfg.gain[16]) begin
            state <= S_WET;
          end else if (mac_rsp.done) begin
            pend  <= 1'b0;
            x     <= mac_rsp.result;
            state <= S_WET;
          end
        end
        S_WET: begin
          if (cfg.wet[16]) begin
            state <= S_OUT;
          end else if (mac_rsp.done) begin
            pend  <= 1'b0;
            x     <= mac_rsp.result;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            out_sample <= x_sat;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_sample;

  a_done_pending: assert property (@(posedge clk) disable iff (rst)
    mac_rsp.done |-> pend)
    else $error("mac result without a pending pass");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == S_TREND || state == S_GAIN))
    else $error("request accepted without starting work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_valid && !out_ch.ready) |=> (state == S_OUT))
    else $error("result overwrote a waiting output");

endmodule
